// ===== design/mcss_pkg.sv =====
// Shared constants, state encoding and controller/datapath interface types.
package mcss_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int LABEL_W          = 16;
  localparam int NB_W             = 16;
  localparam int SIZE_W           = 5;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SEARCH,
    ST_DRAIN,
    ST_EMIT,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic load;
    logic search_start;
    logic scan_step;
    logic emit_load;
    logic emit_skip;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic cur_member;
    logic cur_last;
    logic out_free;
  } status_t;

endpackage

// ===== design/mcss_ctrl.sv =====
// Sequencer: load, subset scan, drain, member output and graph clear.
module mcss_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last_vertex,
  output logic               in_stall,
  input  mcss_pkg::status_t  status,
  output mcss_pkg::cmd_t     cmd
);

  mcss_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcss_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      mcss_pkg::ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last_vertex) begin
            cmd.search_start = 1'b1;
            state_nxt        = mcss_pkg::ST_SEARCH;
          end
        end
      end
      mcss_pkg::ST_SEARCH: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_nxt = mcss_pkg::ST_DRAIN;
        end
      end
      mcss_pkg::ST_DRAIN: begin
        state_nxt = mcss_pkg::ST_EMIT;
      end
      mcss_pkg::ST_EMIT: begin
        if (status.cur_member) begin
          if (status.out_free) begin
            cmd.emit_load = 1'b1;
            if (status.cur_last) begin
              state_nxt = mcss_pkg::ST_CLEAR;
            end
          end
        end else begin
          cmd.emit_skip = 1'b1;
        end
      end
      mcss_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = mcss_pkg::ST_LOAD;
      end
      default: begin
        state_nxt = mcss_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

// ===== design/mcss_dp.sv =====
// Datapath: adjacency rows, labels, subset counter, clique test, best tracker, output register.
module mcss_dp #(
  parameter int MAX_VERTICES = mcss_pkg::MAX_VERTICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mcss_pkg::cmd_t               cmd,
  output mcss_pkg::status_t            status,
  input  logic [mcss_pkg::LABEL_W-1:0] in_vertex_label,
  input  logic [mcss_pkg::NB_W-1:0]    in_neighbor_bits,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [mcss_pkg::LABEL_W-1:0] out_member_label,
  output logic [mcss_pkg::SIZE_W-1:0]  out_clique_size,
  output logic                         out_last_member
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CTR_W = MAX_VERTICES + 1;
  localparam int NBW   = (MAX_VERTICES > mcss_pkg::NB_W) ? MAX_VERTICES : mcss_pkg::NB_W;

  logic [MAX_VERTICES-1:0]      adj_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]      adj_nxt [MAX_VERTICES];
  logic [mcss_pkg::LABEL_W-1:0] labels_r [MAX_VERTICES];
  logic [CNT_W-1:0]             count_r;
  logic [CTR_W-1:0]             ctr_r;
  logic                         valid_a_r;
  logic [MAX_VERTICES-1:0]      sub_a_r;
  logic                         ok_a_r;
  logic [CNT_W-1:0]             pc_a_r;
  logic [MAX_VERTICES-1:0]      best_r;
  logic [CNT_W-1:0]             best_size_r;
  logic [CNT_W-1:0]             idx_r;
  logic                         out_valid_r;
  logic [mcss_pkg::LABEL_W-1:0] out_label_r;
  logic [mcss_pkg::SIZE_W-1:0]  out_size_r;
  logic                         out_last_r;

  logic                         room;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_idx;
  logic [NBW-1:0]               nb_wide;
  logic [MAX_VERTICES-1:0]      sub;
  logic                         bad;
  logic [CNT_W-1:0]             pc;
  logic [CTR_W-1:0]             limit;
  logic [IDX_W-1:0]             idx_i;
  logic                         higher;

  assign room    = count_r < CNT_W'(MAX_VERTICES);
  assign wr_en   = cmd.load && room;
  assign wr_idx  = count_r[IDX_W-1:0];
  assign nb_wide = NBW'(in_neighbor_bits);

  // mirrored row update: own row takes the upper bits, later rows take this vertex's bit
  always_comb begin
    for (int r = 0; r < MAX_VERTICES; r++) begin
      adj_nxt[r] = adj_r[r];
      if (cmd.clear) begin
        adj_nxt[r] = '0;
      end else if (wr_en) begin
        for (int j = 0; j < MAX_VERTICES; j++) begin
          if (j < mcss_pkg::NB_W && nb_wide[j] && CNT_W'(r) == count_r &&
              CNT_W'(j) > count_r) begin
            adj_nxt[r][j] = 1'b1;
          end
          if (r < mcss_pkg::NB_W && nb_wide[r] && CNT_W'(j) == count_r && r > j) begin
            adj_nxt[r][j] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MAX_VERTICES; r++) begin
        adj_r[r] <= '0;
      end
    end else begin
      for (int r = 0; r < MAX_VERTICES; r++) begin
        adj_r[r] <= adj_nxt[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      labels_r[wr_idx] <= in_vertex_label;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (wr_en) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  // clique test: every member's row covers all other members
  assign sub = ctr_r[MAX_VERTICES-1:0];
  assign pc  = CNT_W'($countones(sub));

  always_comb begin
    logic [MAX_VERTICES-1:0] own;
    bad = 1'b0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      own    = '0;
      own[i] = 1'b1;
      if (sub[i] && ((sub & ~adj_r[i] & ~own) != '0)) begin
        bad = 1'b1;
      end
    end
  end

  assign limit = CTR_W'(1) << count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
    end else if (cmd.clear || cmd.search_start) begin
      ctr_r <= '0;
    end else if (cmd.scan_step) begin
      ctr_r <= ctr_r + CTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else begin
      valid_a_r <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    sub_a_r <= sub;
    ok_a_r  <= !bad;
    pc_a_r  <= pc;
  end

  // first strictly larger clique wins
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r      <= '0;
      best_size_r <= '0;
    end else if (cmd.clear || cmd.search_start) begin
      best_r      <= '0;
      best_size_r <= '0;
    end else if (valid_a_r && ok_a_r && pc_a_r > best_size_r) begin
      best_r      <= sub_a_r;
      best_size_r <= pc_a_r;
    end
  end

  // member walk
  assign idx_i = idx_r[IDX_W-1:0];

  always_comb begin
    higher = 1'b0;
    for (int k = 0; k < MAX_VERTICES; k++) begin
      if (CNT_W'(k) > idx_r && best_r[k]) begin
        higher = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.clear || cmd.search_start) begin
      idx_r <= '0;
    end else if (cmd.emit_load || cmd.emit_skip) begin
      idx_r <= idx_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_label_r <= labels_r[idx_i];
      out_size_r  <= mcss_pkg::SIZE_W'(best_size_r);
      out_last_r  <= !higher;
    end
  end

  assign status.scan_last  = (ctr_r + CTR_W'(1)) == limit;
  assign status.cur_member = best_r[idx_i];
  assign status.cur_last   = !higher;
  assign status.out_free   = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_member_label = out_label_r;
  assign out_clique_size  = out_size_r;
  assign out_last_member  = out_last_r;

endmodule

// ===== design/max_clique_subset_search.sv =====
// Top level of the maximum clique subset search block.
//
// Usage: a graph arrives as one input beat per vertex, in local index order.
// Each beat carries the vertex label and its adjacency bits toward later
// vertices; the upper triangle is mirrored into the row store. Beats past
// MAX_VERTICES are dropped, though their last_vertex mark still counts.
// The beat with last_vertex set starts the search: every subset of the n
// loaded vertices is tested, one per cycle, in ascending order, and the
// first clique of greatest size is kept.
// Sequence: after the final beat the subset counter scans every subset, the
// pipeline drains, the member walk steps one index a cycle (holding on a
// member while the output register is stalled), and the graph is cleared.
// Output: one beat per clique member in ascending local index, each with the
// clique size; last_member marks the final one. A single output register
// holds a stalled beat; the member walk waits on it. in_stall is high from
// the state after the final input beat through the clear state, then the next
// graph may load while the last result beat still waits to be taken.
// Reset: rst_n synchronous, active low; clears rows, counts and best clique.
module max_clique_subset_search #(
  parameter int MAX_VERTICES = mcss_pkg::MAX_VERTICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mcss_pkg::LABEL_W-1:0] in_vertex_label,
  input  logic [mcss_pkg::NB_W-1:0]    in_neighbor_bits,
  input  logic                         in_last_vertex,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mcss_pkg::LABEL_W-1:0] out_member_label,
  output logic [mcss_pkg::SIZE_W-1:0]  out_clique_size,
  output logic                         out_last_member
);

  mcss_pkg::cmd_t    cmd;
  mcss_pkg::status_t status;

  // sequencer: owns the input handshake
  mcss_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_last_vertex (in_last_vertex),
    .in_stall       (in_stall),
    .status         (status),
    .cmd            (cmd)
  );

  // storage, clique test and output register
  mcss_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_vertex_label  (in_vertex_label),
    .in_neighbor_bits (in_neighbor_bits),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_member_label (out_member_label),
    .out_clique_size  (out_clique_size),
    .out_last_member  (out_last_member)
  );

endmodule

// ===== design/mcss_chk.sv =====
// Port-level checker for the clique search block, with its bind.
module mcss_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [mcss_pkg::LABEL_W-1:0] in_vertex_label,
  input logic [mcss_pkg::NB_W-1:0]    in_neighbor_bits,
  input logic                         in_last_vertex,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [mcss_pkg::LABEL_W-1:0] out_member_label,
  input logic [mcss_pkg::SIZE_W-1:0]  out_clique_size,
  input logic                         out_last_member
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_member_label) &&
      $stable(out_clique_size) && $stable(out_last_member))
    else $error("stalled result beat changed");

  a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_clique_size != '0)
    else $error("empty clique reported");

  // search begins straight after the final vertex
  a_search_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_vertex |=> in_stall)
    else $error("input taken during search");

  // no loading while a clique is part way out
  a_mid_clique_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_member |-> in_stall)
    else $error("input taken mid clique");

  a_size_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_member |=>
      !out_valid || out_clique_size == $past(out_clique_size))
    else $error("clique size changed within one clique");

endmodule

bind max_clique_subset_search mcss_chk u_mcss_chk (.*);
